@@ rtl/assert_macros.svh @@
// Assertion helpers used by the top RTL file of the gzip accept checker.
// Every check is sampled on the rising edge of clk and is off while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define AEG_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define AEG_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/aeg_pkg.sv @@
// ----------------------------------------------------------------------------
// aeg_pkg
// Types, parser phase codes and character constants of the gzip accept checker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package aeg_pkg;

    typedef logic [7:0] byte_t;
    typedef logic [4:0] phase_t;

    // Parser phases.
    localparam phase_t PH_WS     = 5'd0;
    localparam phase_t PH_SKIP   = 5'd1;
    localparam phase_t PH_G1     = 5'd2;
    localparam phase_t PH_G2     = 5'd3;
    localparam phase_t PH_G3     = 5'd4;
    localparam phase_t PH_X1     = 5'd5;
    localparam phase_t PH_X2     = 5'd6;
    localparam phase_t PH_X3     = 5'd7;
    localparam phase_t PH_X4     = 5'd8;
    localparam phase_t PH_X5     = 5'd9;
    localparam phase_t PH_AFTER  = 5'd10;
    localparam phase_t PH_QWAIT  = 5'd11;
    localparam phase_t PH_EQWAIT = 5'd12;
    localparam phase_t PH_NUMWS  = 5'd13;
    localparam phase_t PH_SIGN   = 5'd14;
    localparam phase_t PH_INT    = 5'd15;
    localparam phase_t PH_FRAC   = 5'd16;

    // Characters.
    localparam byte_t CH_NUL   = 8'h00;
    localparam byte_t CH_TAB   = 8'h09;
    localparam byte_t CH_CR    = 8'h0D;
    localparam byte_t CH_SPACE = 8'h20;
    localparam byte_t CH_STAR  = 8'h2A;
    localparam byte_t CH_PLUS  = 8'h2B;
    localparam byte_t CH_COMMA = 8'h2C;
    localparam byte_t CH_MINUS = 8'h2D;
    localparam byte_t CH_DOT   = 8'h2E;
    localparam byte_t CH_ZERO  = 8'h30;
    localparam byte_t CH_NINE  = 8'h39;
    localparam byte_t CH_SEMI  = 8'h3B;
    localparam byte_t CH_EQ    = 8'h3D;
    localparam byte_t CH_G     = 8'h67;
    localparam byte_t CH_I     = 8'h69;
    localparam byte_t CH_P     = 8'h70;
    localparam byte_t CH_Q     = 8'h71;
    localparam byte_t CH_X     = 8'h78;
    localparam byte_t CH_Z     = 8'h7A;

    // Parser state carried from one word to the next.
    typedef struct packed {
        phase_t phase;
        logic   decided;
        logic   nonzero;
    } parse_state_t;

    // Decision produced by one word.
    typedef struct packed {
        logic valid;
        logic ok;
    } step_res_t;

    function automatic logic is_white(byte_t c);
        return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

    function automatic logic is_digit(byte_t c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    // Character expected next while matching "gzip" or "x-gzip".
    function automatic byte_t tail_char(phase_t p);
        byte_t r;
        r = CH_NUL;
        case (p)
            PH_G1:   r = CH_Z;
            PH_G2:   r = CH_I;
            PH_G3:   r = CH_P;
            PH_X1:   r = CH_MINUS;
            PH_X2:   r = CH_G;
            PH_X3:   r = CH_Z;
            PH_X4:   r = CH_I;
            PH_X5:   r = CH_P;
            default: r = CH_NUL;
        endcase
        return r;
    endfunction

    // Decision when the value ends in the given phase.
    function automatic logic end_decision(phase_t p, logic nz);
        logic r;
        r = 1'b0;
        if (p == PH_AFTER)
        begin
            r = 1'b1;
        end
        else if ((p >= PH_NUMWS) && (p <= PH_FRAC))
        begin
            r = nz;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

@@ rtl/aeg_in_if.sv @@
// ----------------------------------------------------------------------------
// aeg_in_if
// Input channel: one header character per word, with end and absent marks.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface aeg_in_if;
    import aeg_pkg::*;

    logic  valid;
    logic  ready;
    byte_t header_byte;
    logic  last_byte;
    logic  header_absent;

    modport source (output valid, output header_byte, output last_byte,
                    output header_absent, input ready);
    modport sink   (input valid, input header_byte, input last_byte,
                    input header_absent, output ready);
endinterface

`default_nettype wire

@@ rtl/aeg_out_if.sv @@
// ----------------------------------------------------------------------------
// aeg_out_if
// Output channel: one gzip decision per word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface aeg_out_if;
    logic valid;
    logic ready;
    logic gzip_ok;

    modport source (output valid, output gzip_ok, input ready);
    modport sink   (input valid, input gzip_ok, output ready);
endinterface

`default_nettype wire

@@ rtl/aeg_step.sv @@
// ----------------------------------------------------------------------------
// aeg_step
// Next parser state and decision for one header character.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module aeg_step (
    input  wire aeg_pkg::parse_state_t cur,
    input  wire aeg_pkg::byte_t        header_byte,
    input  wire                        last_byte,
    input  wire                        header_absent,
    output aeg_pkg::parse_state_t      nxt,
    output aeg_pkg::step_res_t         res
);
    import aeg_pkg::*;

    typedef struct packed {
        phase_t phase;
        logic   nonzero;
        logic   dvalid;
        logic   dval;
    } cons_t;

    function automatic cons_t consume(phase_t p, logic nz, byte_t c);
        cons_t r;
        logic  white;
        logic  dig;
        logic  comma;
        r.phase   = p;
        r.nonzero = nz;
        r.dvalid  = 1'b0;
        r.dval    = 1'b0;
        white     = is_white(c);
        dig       = is_digit(c);
        comma     = (c == CH_COMMA);
        unique case (p) inside
            PH_WS:
            begin
                if (!white)
                begin
                    if (c == CH_STAR)
                        r.phase = PH_AFTER;
                    else if (c == CH_G)
                        r.phase = PH_G1;
                    else if (c == CH_X)
                        r.phase = PH_X1;
                    else if (comma)
                        r.phase = PH_WS;
                    else
                        r.phase = PH_SKIP;
                end
            end
            PH_G1, PH_G2, PH_G3, PH_X1, PH_X2, PH_X3, PH_X4, PH_X5:
            begin
                if (c == tail_char(p))
                    r.phase = ((p == PH_G3) || (p == PH_X5)) ? PH_AFTER : phase_t'(p + 5'd1);
                else
                    r.phase = comma ? PH_WS : PH_SKIP;
            end
            PH_AFTER:
            begin
                if (!white)
                begin
                    if (comma)
                    begin
                        r.dvalid = 1'b1;
                        r.dval   = 1'b1;
                    end
                    else
                    begin
                        r.phase = (c == CH_SEMI) ? PH_QWAIT : PH_SKIP;
                    end
                end
            end
            PH_QWAIT, PH_EQWAIT:
            begin
                if (!white)
                begin
                    if (c != ((p == PH_QWAIT) ? CH_Q : CH_EQ))
                        r.dvalid = 1'b1;
                    else
                        r.phase = (p == PH_QWAIT) ? PH_EQWAIT : PH_NUMWS;
                end
            end
            PH_NUMWS, PH_SIGN, PH_INT, PH_FRAC:
            begin
                if ((p == PH_NUMWS) && white)
                begin
                    r.phase = p;
                end
                else if ((p == PH_NUMWS) && ((c == CH_PLUS) || (c == CH_MINUS)))
                begin
                    r.phase = PH_SIGN;
                end
                else if (dig)
                begin
                    r.nonzero = nz | (c != CH_ZERO);
                    r.phase   = (p == PH_FRAC) ? PH_FRAC : PH_INT;
                end
                else if ((c == CH_DOT) && (p != PH_FRAC))
                begin
                    r.phase = PH_FRAC;
                end
                else
                begin
                    r.dvalid = 1'b1;
                    r.dval   = nz;
                end
            end
            default:
            begin
                r.phase = comma ? PH_WS : PH_SKIP;
            end
        endcase
        return r;
    endfunction

    cons_t c_res;

    always_comb
    begin
        c_res       = consume(cur.phase, cur.nonzero, header_byte);
        nxt         = cur;
        res.valid   = 1'b0;
        res.ok      = 1'b0;
        if (header_absent)
        begin
            res.valid   = 1'b1;
            res.ok      = 1'b1;
            nxt.phase   = PH_WS;
            nxt.decided = 1'b0;
            nxt.nonzero = 1'b0;
        end
        else
        begin
            if (!cur.decided)
            begin
                // A zero byte ends the value without being parsed.
                if (header_byte == CH_NUL)
                begin
                    res.valid = 1'b1;
                    res.ok    = end_decision(cur.phase, cur.nonzero);
                end
                else
                begin
                    nxt.phase   = c_res.phase;
                    nxt.nonzero = c_res.nonzero;
                    if (c_res.dvalid)
                    begin
                        res.valid = 1'b1;
                        res.ok    = c_res.dval;
                    end
                    else if (last_byte)
                    begin
                        res.valid = 1'b1;
                        res.ok    = end_decision(c_res.phase, c_res.nonzero);
                    end
                end
                nxt.decided = res.valid;
            end
            if (last_byte)
            begin
                nxt.phase   = PH_WS;
                nxt.decided = 1'b0;
                nxt.nonzero = 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

@@ rtl/aeg_out_stage.sv @@
// ----------------------------------------------------------------------------
// aeg_out_stage
// Result register that holds a decision until the output side takes it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module aeg_out_stage (
    input  wire                      clk,
    input  wire                      rst_n,
    input  wire                      load,
    input  wire aeg_pkg::step_res_t  res,
    output logic                     free,
    aeg_out_if.source                rsp
);
    import aeg_pkg::*;

    logic valid_reg;
    logic ok_reg;

    // The register can take a new word when empty or when its word leaves now.
    assign free        = !valid_reg || rsp.ready;
    assign rsp.valid   = valid_reg;
    assign rsp.gzip_ok = ok_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            ok_reg <= res.ok;
        end
    end

endmodule

`default_nettype wire

@@ rtl/accept_encoding_gzip_checker.sv @@
// Path: an accepted word waits in the input register and is parsed once the result register is free;
// any decision it makes is then registered in the result register and shown on rsp.
// Throughput: one header character per cycle while the result register is free; the parser state updates once per word.
// While a decision waits on rsp, the input register still takes one word, then ready drops.
// Reset: rst_n clears the parser to the start of an entry and empties both registers.
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// accept_encoding_gzip_checker
// Decides from an Accept-Encoding value, one byte per word, whether gzip is allowed.
// ----------------------------------------------------------------------------

module accept_encoding_gzip_checker (
    input  wire       clk,
    input  wire       rst_n,
    aeg_in_if.sink    req,
    aeg_out_if.source rsp
);
    import aeg_pkg::*;

    `include "assert_macros.svh"

    logic         in_valid_reg;
    byte_t        in_byte_reg;
    logic         in_last_reg;
    logic         in_absent_reg;
    parse_state_t state_reg;
    parse_state_t state_next;
    step_res_t    step_res;
    logic         out_free;
    logic         take;
    logic         state_idle;

    // The registered word is parsed whenever the result register can take it.
    assign take      = in_valid_reg && out_free;
    assign req.ready = !in_valid_reg || out_free;

    assign state_idle = (state_reg.phase == PH_WS) && !state_reg.decided && !state_reg.nonzero;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (req.ready)
        begin
            in_valid_reg <= req.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.ready && req.valid)
        begin
            in_byte_reg   <= req.header_byte;
            in_last_reg   <= req.last_byte;
            in_absent_reg <= req.header_absent;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.phase   <= PH_WS;
            state_reg.decided <= 1'b0;
            state_reg.nonzero <= 1'b0;
        end
        else if (take)
        begin
            state_reg <= state_next;
        end
    end

    aeg_step u_step (
        .cur           (state_reg),
        .header_byte   (in_byte_reg),
        .last_byte     (in_last_reg),
        .header_absent (in_absent_reg),
        .nxt           (state_next),
        .res           (step_res)
    );

    aeg_out_stage u_out (
        .clk   (clk),
        .rst_n (rst_n),
        .load  (take && step_res.valid),
        .res   (step_res),
        .free  (out_free),
        .rsp   (rsp)
    );

    `AEG_ASSERT_NEXT(a_absent_accepts, take && in_absent_reg,
                     rsp.valid && rsp.gzip_ok, "absent header did not accept")
    `AEG_ASSERT_NEXT(a_last_clears, take && in_last_reg,
                     state_idle, "state not cleared after last byte")
    `AEG_ASSERT_NEXT(a_decided_holds, take && state_reg.decided && !in_last_reg && !in_absent_reg,
                     state_reg.decided && $stable(state_reg.phase), "decided header changed state")
    `AEG_ASSERT_NOW(a_one_decision, take && state_reg.decided && !in_absent_reg,
                    !step_res.valid, "second decision for one header")

endmodule

`default_nettype wire

@@ bench/gzip_decision_monitor.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gzip_decision_monitor
// Watches both channels of the gzip accept checker, predicts the decision for
// every header value from the accepted bytes, and compares each returned word.
// ----------------------------------------------------------------------------

module gzip_decision_monitor
    import aeg_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    aeg_in_if    req,
    aeg_out_if   rsp,
    output int   fail_count,
    output int   decisions_waiting,
    output int   words_seen,
    output int   decisions_seen
);

    typedef struct packed {
        phase_t phase;
        logic   done;
        logic   nz;
    } scan_state_t;

    localparam scan_state_t SCAN_CLEAR = '{PH_WS, 1'b0, 1'b0};

    scan_state_t scan;
    logic        decision_q[$];
    logic        wanted;
    int          verdict;

    function automatic logic white_char(byte_t c);
        return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

    function automatic int end_verdict();
        if (scan.phase == PH_AFTER)
        begin
            return 1;
        end
        if ((scan.phase >= PH_NUMWS) && (scan.phase <= PH_FRAC))
        begin
            return scan.nz ? 1 : 0;
        end
        return 0;
    endfunction

    // Advances the scan by one character; returns -1 while undecided.
    function automatic int scan_char(byte_t c);
        logic  digit;
        byte_t want;
        int    d;
        digit = (c >= CH_ZERO) && (c <= CH_NINE);
        d = -1;
        case (scan.phase)
            PH_WS:
            begin
                if (!white_char(c))
                begin
                    if (c == CH_STAR)
                        scan.phase = PH_AFTER;
                    else if (c == CH_G)
                        scan.phase = PH_G1;
                    else if (c == CH_X)
                        scan.phase = PH_X1;
                    else if (c == CH_COMMA)
                        scan.phase = PH_WS;
                    else
                        scan.phase = PH_SKIP;
                end
            end
            PH_G1, PH_G2, PH_G3, PH_X1, PH_X2, PH_X3, PH_X4, PH_X5:
            begin
                case (scan.phase)
                    PH_G1:   want = CH_Z;
                    PH_G2:   want = CH_I;
                    PH_G3:   want = CH_P;
                    PH_X1:   want = CH_MINUS;
                    PH_X2:   want = CH_G;
                    PH_X3:   want = CH_Z;
                    PH_X4:   want = CH_I;
                    default: want = CH_P;
                endcase
                if (c == want)
                    scan.phase = ((scan.phase == PH_G3) || (scan.phase == PH_X5)) ?
                                 PH_AFTER : phase_t'(scan.phase + 5'd1);
                else
                    scan.phase = (c == CH_COMMA) ? PH_WS : PH_SKIP;
            end
            PH_AFTER:
            begin
                if (!white_char(c))
                begin
                    if (c == CH_COMMA)
                        d = 1;
                    else
                        scan.phase = (c == CH_SEMI) ? PH_QWAIT : PH_SKIP;
                end
            end
            PH_QWAIT:
            begin
                if (!white_char(c))
                begin
                    if (c != CH_Q)
                        d = 0;
                    else
                        scan.phase = PH_EQWAIT;
                end
            end
            PH_EQWAIT:
            begin
                if (!white_char(c))
                begin
                    if (c != CH_EQ)
                        d = 0;
                    else
                        scan.phase = PH_NUMWS;
                end
            end
            PH_NUMWS, PH_SIGN:
            begin
                if ((scan.phase == PH_NUMWS) && white_char(c))
                    d = -1;
                else if ((scan.phase == PH_NUMWS) && ((c == CH_PLUS) || (c == CH_MINUS)))
                    scan.phase = PH_SIGN;
                else if (digit)
                begin
                    scan.nz = scan.nz | (c != CH_ZERO);
                    scan.phase = PH_INT;
                end
                else if (c == CH_DOT)
                    scan.phase = PH_FRAC;
                else
                    d = scan.nz ? 1 : 0;
            end
            PH_INT:
            begin
                if (digit)
                    scan.nz = scan.nz | (c != CH_ZERO);
                else if (c == CH_DOT)
                    scan.phase = PH_FRAC;
                else
                    d = scan.nz ? 1 : 0;
            end
            PH_FRAC:
            begin
                if (digit)
                    scan.nz = scan.nz | (c != CH_ZERO);
                else
                    d = scan.nz ? 1 : 0;
            end
            default:
            begin
                scan.phase = (c == CH_COMMA) ? PH_WS : PH_SKIP;
            end
        endcase
        return d;
    endfunction

    task automatic report_mismatch(string what);
        $display("%0t ns: mismatch: %s", $time, what);
        fail_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan = SCAN_CLEAR;
            decision_q.delete();
            fail_count = 0;
            decisions_waiting = 0;
            words_seen = 0;
            decisions_seen = 0;
        end
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                decisions_seen++;
                if (decision_q.size() == 0)
                begin
                    report_mismatch($sformatf("decision %0b returned with none pending",
                                              rsp.gzip_ok));
                end
                else
                begin
                    wanted = decision_q.pop_front();
                    if (rsp.gzip_ok !== wanted)
                    begin
                        report_mismatch($sformatf("gzip_ok is %0b, predicted %0b",
                                                  rsp.gzip_ok, wanted));
                    end
                end
            end
            if (req.valid && req.ready)
            begin
                words_seen++;
                if (req.header_absent)
                begin
                    // No header at all means any coding is fine.
                    decision_q.push_back(1'b1);
                    scan = SCAN_CLEAR;
                end
                else
                begin
                    if (!scan.done)
                    begin
                        verdict = (req.header_byte == CH_NUL) ? end_verdict() :
                                  scan_char(req.header_byte);
                        if ((verdict < 0) && req.last_byte)
                            verdict = end_verdict();
                        if (verdict >= 0)
                        begin
                            decision_q.push_back(verdict[0]);
                            scan.done = 1'b1;
                        end
                    end
                    if (req.last_byte)
                        scan = SCAN_CLEAR;
                end
            end
            decisions_waiting = decision_q.size();
        end
    end

endmodule

@@ bench/accept_encoding_gzip_checker_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// accept_encoding_gzip_checker_test
// Drives Accept-Encoding values into the gzip accept checker: a directed set of
// corner cases, then random well-formed and broken lists with random stalls on
// both channels. The monitor predicts and checks every decision.
// ----------------------------------------------------------------------------

module accept_encoding_gzip_checker_test;
    import aeg_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int WORD_TARGET  = 1800;
    localparam int DRAIN_CYCLES = 20;

    logic clk;
    logic rst_n;

    aeg_in_if  req();
    aeg_out_if rsp();

    int fail_count;
    int decisions_waiting;
    int words_seen;
    int decisions_seen;

    int    cycle_count;
    int    headers_sent;
    int    absent_sent;
    logic  send_burst;
    logic  recv_burst;
    logic  absent_noise;
    byte_t hdr[$];

    accept_encoding_gzip_checker dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    gzip_decision_monitor monitor (
        .clk               (clk),
        .rst_n             (rst_n),
        .req               (req),
        .rsp               (rsp),
        .fail_count        (fail_count),
        .decisions_waiting (decisions_waiting),
        .words_seen        (words_seen),
        .decisions_seen    (decisions_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d decisions outstanding",
                     cycle_count, decisions_waiting);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Result side: hold ready low for a random stall before taking each word, except in bursts.
    initial
    begin
        int stall;
        rsp.ready = 1'b0;
        recv_burst = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            if ($urandom_range(0, 7) == 0)
                recv_burst = ~recv_burst;
            stall = recv_burst ? 0 : $urandom_range(0, 7);
            if (stall > 0)
            begin
                rsp.ready = 1'b0;
                repeat (stall) @(negedge clk);
            end
            rsp.ready = 1'b1;
            @(posedge clk);
            while (!rsp.valid)
                @(posedge clk);
            @(negedge clk);
        end
    end

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_word(byte_t c, logic last, logic absent);
        int gap;
        gap = send_burst ? 0 : $urandom_range(0, 7);
        if (gap > 0)
        begin
            req.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        req.valid         = 1'b1;
        req.header_byte   = c;
        req.last_byte     = last;
        req.header_absent = absent;
        if (absent)
            absent_sent++;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic send_header();
        for (int i = 0; i < hdr.size(); i++)
        begin
            if (absent_noise && ($urandom_range(0, 79) == 0))
                send_word(byte_t'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1);
            send_word(hdr[i], i == hdr.size() - 1, 1'b0);
        end
        hdr.delete();
        headers_sent++;
        if ($urandom_range(0, 9) == 0)
            send_burst = ~send_burst;
    endtask

    task automatic wait_all_decisions();
        req.valid = 1'b0;
        while (decisions_waiting != 0)
            @(negedge clk);
    endtask

    function automatic void put_text(string s);
        for (int i = 0; i < s.len(); i++)
            hdr.push_back(byte_t'(s[i]));
    endfunction

    function automatic void put_space();
        int n;
        n = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 2) : 0;
        repeat (n)
        begin
            case ($urandom_range(0, 3))
                0, 1:    hdr.push_back(CH_SPACE);
                2:       hdr.push_back(CH_TAB);
                default: hdr.push_back(byte_t'(CH_TAB + $urandom_range(1, 4)));
            endcase
        end
    endfunction

    function automatic void put_digits(int n);
        repeat (n)
            hdr.push_back($urandom_range(0, 1) ? CH_ZERO :
                          byte_t'(CH_ZERO + $urandom_range(0, 9)));
    endfunction

    function automatic void put_number();
        case ($urandom_range(0, 5))
            0:       hdr.push_back(CH_PLUS);
            1:       hdr.push_back(CH_MINUS);
            default: ;
        endcase
        put_digits($urandom_range(0, 3));
        if ($urandom_range(0, 1))
        begin
            hdr.push_back(CH_DOT);
            put_digits($urandom_range(0, 3));
        end
        case ($urandom_range(0, 5))
            0:       put_text("e5");
            1:       put_text("x1");
            default: ;
        endcase
    endfunction

    function automatic void put_entry();
        case ($urandom_range(0, 9))
            0, 1: put_text("gzip");
            2:    put_text("x-gzip");
            3:    hdr.push_back(CH_STAR);
            4:    put_text("deflate");
            5:    put_text("br");
            6:
            begin
                case ($urandom_range(0, 3))
                    0:       put_text("gz");
                    1:       put_text("x-g");
                    2:       put_text("gzipx");
                    default: put_text("g");
                endcase
            end
            7:
            begin
                repeat ($urandom_range(1, 4))
                    hdr.push_back(byte_t'($urandom_range(0, 255)));
            end
            8:       put_text("identity");
            default: put_text("GZIP");
        endcase
        case ($urandom_range(0, 5))
            2, 3:
            begin
                put_space();
                hdr.push_back(CH_SEMI);
                put_space();
                hdr.push_back(CH_Q);
                put_space();
                hdr.push_back(CH_EQ);
                put_space();
                put_number();
            end
            4:
            begin
                hdr.push_back(CH_SEMI);
                case ($urandom_range(0, 3))
                    0:       put_text("q");
                    1:       put_text("q=");
                    2:       put_text("x=1");
                    default: put_text("q 1");
                endcase
            end
            5:       put_text(";level=1");
            default: ;
        endcase
        put_space();
    endfunction

    initial
    begin
        int entries;
        rst_n             = 1'b0;
        req.valid         = 1'b0;
        req.header_byte   = CH_NUL;
        req.last_byte     = 1'b0;
        req.header_absent = 1'b0;
        cycle_count       = 0;
        headers_sent      = 0;
        absent_sent       = 0;
        send_burst        = 1'b0;
        absent_noise      = 1'b0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed part.
        put_text("gzip");                   send_header();
        hdr.push_back(CH_STAR);             send_header();
        put_text("x-gzip, deflate");        send_header();
        put_text("deflate");                send_header();
        put_text("gzip;q=0");               send_header();
        put_text("gzip ; q = 0.5");         send_header();
        put_text("gzip;q=-1,br");           send_header();
        put_text("gzip;x");                 send_header();
        put_text("gzip;q x");               send_header();
        put_text("gz,gzip");                send_header();
        put_text("gzipper");                send_header();
        put_text("gzip;q=0x1");             send_header();
        put_text("gzip;q=+.5e3");           send_header();
        put_text("gzip;q=");                send_header();
        hdr.push_back(CH_TAB);
        put_text("gzip");
        hdr.push_back(CH_CR);               send_header();
        // A zero byte ends the value early; the rest is ignored.
        hdr.push_back(CH_NUL);
        put_text("gzip");                   send_header();
        put_text("gzip");
        hdr.push_back(CH_NUL);
        put_text(",br");                    send_header();
        hdr.push_back(8'hFF);
        put_text("gzip");                   send_header();
        // Absent header with and without the last mark, and one cutting a value short.
        send_word(8'hFF, 1'b0, 1'b1);
        send_word(CH_NUL, 1'b1, 1'b1);
        send_word(CH_G, 1'b0, 1'b0);
        send_word(CH_Z, 1'b0, 1'b0);
        send_word(8'h5A, 1'b1, 1'b1);
        wait_all_decisions();

        // Random part.
        absent_noise = 1'b1;
        while (words_seen < WORD_TARGET)
        begin
            if ($urandom_range(0, 11) == 0)
            begin
                repeat ($urandom_range(1, 10))
                    hdr.push_back(byte_t'($urandom_range(0, 255)));
            end
            else
            begin
                put_space();
                entries = $urandom_range(1, 4);
                for (int e = 0; e < entries; e++)
                begin
                    if (e > 0)
                    begin
                        hdr.push_back(CH_COMMA);
                        put_space();
                    end
                    put_entry();
                end
                if ($urandom_range(0, 9) == 0)
                    hdr.push_back(CH_NUL);
            end
            send_header();
            if ($urandom_range(0, 14) == 0)
                send_word(byte_t'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1);
            if ($urandom_range(0, 49) == 0)
                wait_all_decisions();
        end

        wait_all_decisions();
        repeat (DRAIN_CYCLES) @(negedge clk);
        $display("Sent %0d words in %0d header values, %0d of them absent-header words.",
                 words_seen, headers_sent, absent_sent);
        $display("Checked %0d gzip decisions over %0d cycles.", decisions_seen, cycle_count);
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
